// ----- src/tfp_pkg.sv -----
// tfp_pkg: shared constants and types for the target frame parser
// no dependencies; imported by tfp_num_parse, target_frame_parser and the testbench

package tfp_pkg;

    // store depth default and fixed layout of a target frame
    localparam int STORE_DEPTH_DEF = 32;
    localparam int HOLD_LEN        = 17;   // only bytes 0..16 are ever read back
    localparam int NUM_CHARS       = 4;    // optional sign plus up to three digits
    localparam int MAX_DIGITS      = 3;

    localparam int POS_X_TAG = 0;
    localparam int POS_X_VAL = 2;
    localparam int POS_Y_TAG = 6;
    localparam int POS_Y_VAL = 8;
    localparam int POS_Q_TAG = 12;
    localparam int POS_Q_VAL = 14;

    // field widths
    localparam int BYTE_W = 8;
    localparam int MAG_W  = 10;   // up to 999
    localparam int VAL_W  = 11;   // signed target value
    localparam int Q_W    = 8;
    localparam int TIME_W = 32;
    localparam int DIG_W  = 4;

    localparam int Q_MAX       = 255;
    localparam int LIMIT_RESET = 100;

    // character codes
    localparam logic [BYTE_W-1:0] CH_RESTART = 8'h24;   // '$'
    localparam logic [BYTE_W-1:0] CH_END     = 8'h23;   // '#'
    localparam logic [BYTE_W-1:0] CH_X       = 8'h58;   // 'X'
    localparam logic [BYTE_W-1:0] CH_Y       = 8'h59;   // 'Y'
    localparam logic [BYTE_W-1:0] CH_Q       = 8'h51;   // 'Q'
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;   // '-'
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;   // '+'
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;   // '0'
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;   // '9'
    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;

    // input command
    typedef enum logic {
        CMD_BYTE  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // decimal digit test
    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ----- src/target_frame_parser.sv -----
// target_frame_parser: frame receiver that keeps the last parsed target
// depends on tfp_pkg and tfp_num_parse
//
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    cmd, rx_byte, now_ms
// out      output     out_valid / out_stall  frame_accepted, target_valid,
//                                            target_x, target_y, target_quality
// cfg      input      cfg_valid / cfg_ready  cfg_fresh_limit_ms
//
// one word per cycle unless out_stall holds the result; a taken word moves
// through the input register, then parse and state update into the result register
// the parse stage and state update are a single pass of logic on the input register
// reset clears the store, write position, target and frame time, and sets the limit to 100 ms
// out_stall holds the result register, and in_stall rises only while a word waits
// behind a held result; cfg_ready is always high

module target_frame_parser #(
    parameter int STORE_DEPTH = tfp_pkg::STORE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [tfp_pkg::BYTE_W-1:0]        rx_byte,
    input  logic [tfp_pkg::TIME_W-1:0]        now_ms,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              frame_accepted,
    output logic                              target_valid,
    output logic signed [tfp_pkg::VAL_W-1:0]  target_x,
    output logic signed [tfp_pkg::VAL_W-1:0]  target_y,
    output logic [tfp_pkg::Q_W-1:0]           target_quality,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tfp_pkg::TIME_W-1:0]        cfg_fresh_limit_ms
);
    import tfp_pkg::*;

    localparam int              WIDX_W   = $clog2(STORE_DEPTH);
    localparam logic [WIDX_W-1:0] LAST_IDX = WIDX_W'(STORE_DEPTH - 1);

    // input register
    logic                  s1_valid_reg;
    logic                  s1_cmd_reg;
    logic [BYTE_W-1:0]     s1_byte_reg;
    logic [TIME_W-1:0]     s1_now_reg;

    // block state
    logic [BYTE_W-1:0]     store_reg [0:HOLD_LEN-1];
    logic [WIDX_W-1:0]     wi_reg, wi_next;
    logic signed [VAL_W-1:0] x_reg, y_reg;
    logic [Q_W-1:0]        q_reg;
    logic                  have_reg;
    logic [TIME_W-1:0]     ftime_reg;
    logic [TIME_W-1:0]     limit_reg;

    // result register
    logic                  out_valid_reg;
    logic                  acc_reg;
    logic                  tvalid_reg;
    logic signed [VAL_W-1:0] tx_reg, ty_reg;
    logic [Q_W-1:0]        tq_reg;

    // parse stage signals
    logic                  advance, load;
    logic                  is_byte, is_restart, is_end, is_data, can_write;
    logic [BYTE_W-1:0]     view [0:HOLD_LEN-1];
    logic                  markers_ok, accept;
    logic [TIME_W-1:0]     age;
    logic                  valid_now;
    logic [MAG_W-1:0]      x_mag, y_mag, q_mag;
    logic                  x_neg, y_neg, q_neg;
    logic signed [VAL_W-1:0] new_x, new_y;
    logic [Q_W-1:0]        new_q;

    // handshake
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign load      = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // byte decode and write position
    always_comb
    begin
        is_byte    = (s1_cmd_reg == CMD_BYTE);
        is_restart = is_byte && (s1_byte_reg == CH_RESTART);
        is_end     = is_byte && (s1_byte_reg == CH_END);
        is_data    = is_byte && !is_restart && !is_end;
        can_write  = is_data && (wi_reg < LAST_IDX);
        wi_next    = wi_reg;
        priority if (is_restart || is_end)
            wi_next = '0;
        else if (can_write)
            wi_next = wi_reg + WIDX_W'(1);
    end

    // store as seen by the parser, with the terminating zero in place
    always_comb
    begin
        for (int i = 0; i < HOLD_LEN; i++)
        begin
            if (is_end && (wi_reg == WIDX_W'(i)))
                view[i] = CH_NUL;
            else
                view[i] = store_reg[i];
        end
    end

    // field readers
    tfp_num_parse u_parse_x (
        .chars   ({view[POS_X_VAL+3], view[POS_X_VAL+2], view[POS_X_VAL+1], view[POS_X_VAL]}),
        .sign_en (1'b1),
        .mag     (x_mag),
        .neg     (x_neg)
    );

    tfp_num_parse u_parse_y (
        .chars   ({view[POS_Y_VAL+3], view[POS_Y_VAL+2], view[POS_Y_VAL+1], view[POS_Y_VAL]}),
        .sign_en (1'b1),
        .mag     (y_mag),
        .neg     (y_neg)
    );

    tfp_num_parse u_parse_q (
        .chars   ({CH_NUL, view[POS_Q_VAL+2], view[POS_Q_VAL+1], view[POS_Q_VAL]}),
        .sign_en (1'b0),
        .mag     (q_mag),
        .neg     (q_neg)
    );

    // marker match, signed values, quality clamp and freshness
    always_comb
    begin
        markers_ok = (view[POS_X_TAG] == CH_X) && (view[POS_Y_TAG] == CH_Y) &&
                     (view[POS_Q_TAG] == CH_Q);
        accept     = is_end && markers_ok;
        new_x      = x_neg ? -$signed({1'b0, x_mag}) : $signed({1'b0, x_mag});
        new_y      = y_neg ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
        // quality reader has no sign, so q_neg stays low
        if (q_neg || (q_mag > MAG_W'(Q_MAX)))
            new_q = Q_W'(Q_MAX);
        else
            new_q = q_mag[Q_W-1:0];
        age        = s1_now_reg - ftime_reg;
        valid_now  = accept || (have_reg && (age <= limit_reg));
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (load)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_cmd_reg  <= cmd;
            s1_byte_reg <= rx_byte;
            s1_now_reg  <= now_ms;
        end
    end

    // frame store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HOLD_LEN; i++)
                store_reg[i] <= '0;
        end
        else if (advance)
        begin
            for (int i = 0; i < HOLD_LEN; i++)
            begin
                if (wi_reg == WIDX_W'(i))
                begin
                    if (is_end)
                        store_reg[i] <= CH_NUL;
                    else if (can_write)
                        store_reg[i] <= s1_byte_reg;
                end
            end
        end
    end

    // target state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg    <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            q_reg     <= '0;
            have_reg  <= 1'b0;
            ftime_reg <= '0;
        end
        else if (advance)
        begin
            wi_reg <= wi_next;
            if (accept)
            begin
                x_reg     <= new_x;
                y_reg     <= new_y;
                q_reg     <= new_q;
                have_reg  <= 1'b1;
                ftime_reg <= s1_now_reg;
            end
        end
    end

    // freshness limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= TIME_W'(LIMIT_RESET);
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_fresh_limit_ms;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            acc_reg    <= accept;
            tvalid_reg <= valid_now;
            tx_reg     <= accept ? new_x : x_reg;
            ty_reg     <= accept ? new_y : y_reg;
            tq_reg     <= accept ? new_q : q_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_accepted = acc_reg;
    assign target_valid   = tvalid_reg;
    assign target_x       = tx_reg;
    assign target_y       = ty_reg;
    assign target_quality = tq_reg;

    // checks
    a_accept_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_accepted |-> target_valid)
        else $error("accepted frame reported as stale");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wi_reg <= LAST_IDX)
        else $error("write position beyond store");

    a_query_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (s1_cmd_reg == CMD_QUERY) |=> out_valid_reg && !acc_reg)
        else $error("query word accepted a frame");

    a_have_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        have_reg |=> have_reg)
        else $error("target lost after being set");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a held result");

endmodule

// ----- src/tfp_num_parse.sv -----
// tfp_num_parse: decimal field reader, optional sign then up to three digits
// depends on tfp_pkg

module tfp_num_parse (
    input  logic [tfp_pkg::NUM_CHARS-1:0][tfp_pkg::BYTE_W-1:0] chars,
    input  logic                                               sign_en,
    output logic [tfp_pkg::MAG_W-1:0]                          mag,
    output logic                                               neg
);
    import tfp_pkg::*;

    logic                  has_sign;
    logic [BYTE_W-1:0]     d0, d1, d2;
    logic                  ok0, ok1, ok2;
    logic [MAG_W-1:0]      v0, v1, v2;

    // sign detection and digit window
    always_comb
    begin
        has_sign = sign_en && ((chars[0] == CH_MINUS) || (chars[0] == CH_PLUS));
        neg      = sign_en && (chars[0] == CH_MINUS);
        if (has_sign)
        begin
            d0 = chars[1];
            d1 = chars[2];
            d2 = chars[3];
        end
        else
        begin
            d0 = chars[0];
            d1 = chars[1];
            d2 = chars[2];
        end
    end

    // digit run stops at the first non-digit
    always_comb
    begin
        ok0 = is_digit(d0);
        ok1 = ok0 && is_digit(d1);
        ok2 = ok1 && is_digit(d2);
        v0  = MAG_W'(d0[DIG_W-1:0]);
        v1  = MAG_W'(d1[DIG_W-1:0]);
        v2  = MAG_W'(d2[DIG_W-1:0]);
        priority if (ok2)
            mag = v0 * MAG_W'(100) + v1 * MAG_W'(10) + v2;
        else if (ok1)
            mag = v0 * MAG_W'(10) + v1;
        else if (ok0)
            mag = v0;
        else
            mag = '0;
    end

endmodule

// ----- verif/tb_target_frame_parser.sv -----
// tb_target_frame_parser: self-checking bench for the target frame parser
// feeds framed byte streams with random idling and checks every result word in order
// depends on tfp_pkg and target_frame_parser

module tb_target_frame_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import tfp_pkg::*;

    localparam int DEPTH       = STORE_DEPTH_DEF;
    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_WORDS = 300;

    // one result word as the block presents it
    typedef struct packed {
        logic                    accepted;
        logic                    fresh;
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic [Q_W-1:0]          quality;
    } target_word_t;

    // frame receiver model plus the queue of target words still owed
    class target_tracker;
        logic [BYTE_W-1:0]       frame_bytes [DEPTH];
        int unsigned             wr_pos;
        logic signed [VAL_W-1:0] x_held;
        logic signed [VAL_W-1:0] y_held;
        logic [Q_W-1:0]          q_held;
        logic                    have_fix;
        logic [TIME_W-1:0]       fix_time;
        logic [TIME_W-1:0]       age_limit;
        target_word_t            expected_targets [$];
        int                      errors;
        int                      checked;
        int                      frames_taken;

        function new();
            foreach (frame_bytes[i])
                frame_bytes[i] = CH_NUL;
            wr_pos       = 0;
            x_held       = '0;
            y_held       = '0;
            q_held       = '0;
            have_fix     = 1'b0;
            fix_time     = '0;
            age_limit    = LIMIT_RESET;
            errors       = 0;
            checked      = 0;
            frames_taken = 0;
        endfunction

        function void set_limit(logic [TIME_W-1:0] v);
            age_limit = v;
        endfunction

        // up to three decimal digits, stopping at the first non-digit
        function int digits_at(int unsigned pos);
            int v;
            v = 0;
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                if (pos + i >= DEPTH)
                    break;
                if (frame_bytes[pos + i] < CH_ZERO || frame_bytes[pos + i] > CH_NINE)
                    break;
                v = v * 10 + int'(frame_bytes[pos + i] - CH_ZERO);
            end
            return v;
        endfunction

        // optional sign then digits
        function logic signed [VAL_W-1:0] signed_at(int unsigned pos);
            logic neg;
            int   v;
            neg = (frame_bytes[pos] == CH_MINUS);
            if (frame_bytes[pos] == CH_MINUS || frame_bytes[pos] == CH_PLUS)
                pos++;
            v = digits_at(pos);
            return VAL_W'(neg ? -v : v);
        endfunction

        // update the receiver state for one accepted input word
        function void note_word(cmd_t c, logic [BYTE_W-1:0] b, logic [TIME_W-1:0] t);
            target_word_t      w;
            logic [TIME_W-1:0] age;
            int                q;
            w.accepted = 1'b0;
            if (c == CMD_BYTE)
            begin
                if (b == CH_RESTART)
                    wr_pos = 0;
                else if (b == CH_END)
                begin
                    frame_bytes[wr_pos] = CH_NUL;
                    if (frame_bytes[POS_X_TAG] == CH_X && frame_bytes[POS_Y_TAG] == CH_Y &&
                        frame_bytes[POS_Q_TAG] == CH_Q)
                    begin
                        x_held   = signed_at(POS_X_VAL);
                        y_held   = signed_at(POS_Y_VAL);
                        q        = digits_at(POS_Q_VAL);
                        q_held   = Q_W'(q > Q_MAX ? Q_MAX : q);
                        have_fix = 1'b1;
                        fix_time = t;
                        w.accepted = 1'b1;
                        frames_taken++;
                    end
                    wr_pos = 0;
                end
                else if (wr_pos < DEPTH - 1)
                begin
                    frame_bytes[wr_pos] = b;
                    wr_pos++;
                end
            end
            age       = t - fix_time;
            w.fresh   = have_fix && (age <= age_limit);
            w.x       = x_held;
            w.y       = y_held;
            w.quality = q_held;
            expected_targets.push_back(w);
        endfunction

        function void report(string field, logic signed [31:0] want_v,
                             logic signed [31:0] got_v);
            if (got_v !== want_v)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
                errors++;
            end
        endfunction

        // compare one result word with the oldest one owed
        function void check_word(target_word_t got);
            target_word_t want;
            checked++;
            if (expected_targets.size() == 0)
            begin
                $display("%0t: stray result, expected none, got acc %b fresh %b x %0d y %0d q %0d",
                         $time, got.accepted, got.fresh, got.x, got.y, got.quality);
                errors++;
                return;
            end
            want = expected_targets.pop_front();
            report("frame_accepted", want.accepted, got.accepted);
            report("target_valid", want.fresh, got.fresh);
            report("target_x", want.x, got.x);
            report("target_y", want.y, got.y);
            report("target_quality", want.quality, got.quality);
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     cmd;
    logic [BYTE_W-1:0]        rx_byte;
    logic [TIME_W-1:0]        now_ms;
    logic                     out_valid;
    logic                     out_stall;
    logic                     frame_accepted;
    logic                     target_valid;
    logic signed [VAL_W-1:0]  target_x;
    logic signed [VAL_W-1:0]  target_y;
    logic [Q_W-1:0]           target_quality;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [TIME_W-1:0]        cfg_fresh_limit_ms;

    target_tracker     tracker;
    int                send_gap_pct = 16;
    int                recv_gap_pct = 45;
    int                words_sent   = 0;
    int                quiet_cycles = 0;
    logic [TIME_W-1:0] clock_ms     = '0;

    target_frame_parser u_top (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_gap_pct);

    // result words are checked mid-cycle, ahead of the edge that takes them
    always @(negedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            tracker.check_word({frame_accepted, target_valid, target_x, target_y,
                                target_quality});
    end

    // watchdog on cycles where no word moves
    always @(negedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
            (cfg_valid && cfg_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one input word, with a random gap ahead of it
    task automatic send_word(cmd_t c, logic [BYTE_W-1:0] b, logic [TIME_W-1:0] t);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        rx_byte  <= b;
        now_ms   <= t;
        forever
        begin
            @(negedge clk);
            if (in_stall === 1'b0)
                break;
            @(posedge clk);
        end
        tracker.note_word(c, b, t);
        words_sent++;
        @(posedge clk);
    endtask

    task automatic send_text(string s, logic [TIME_W-1:0] t);
        for (int i = 0; i < s.len(); i++)
            send_word(CMD_BYTE, s[i], t);
    endtask

    // wait until every owed result word has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.expected_targets.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [TIME_W-1:0] v);
        cfg_valid          <= 1'b1;
        cfg_fresh_limit_ms <= v;
        forever
        begin
            @(negedge clk);
            if (cfg_ready === 1'b1)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_limit(v);
    endtask

    // time mostly creeps, sometimes leaps anywhere in the 32-bit range
    function automatic logic [TIME_W-1:0] next_ms();
        case ($urandom_range(0, 19))
            0:       clock_ms = $urandom;
            1, 2:    clock_ms = clock_ms + $urandom_range(0, 400);
            default: clock_ms = clock_ms + $urandom_range(0, 2);
        endcase
        return clock_ms;
    endfunction

    // any byte that neither restarts nor ends a frame
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] v;
        do
            v = BYTE_W'($urandom_range(0, 255));
        while (v == CH_RESTART || v == CH_END);
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] digit_or_plain();
        if ($urandom_range(0, 99) < 80)
            return CH_ZERO + BYTE_W'($urandom_range(0, 9));
        return plain_byte();
    endfunction

    function automatic logic [BYTE_W-1:0] sign_or_digit();
        case ($urandom_range(0, 3))
            0:       return CH_MINUS;
            1:       return CH_PLUS;
            2:       return CH_ZERO + BYTE_W'($urandom_range(0, 9));
            default: return plain_byte();
        endcase
    endfunction

    // one frame: mostly well formed, some short, overlong or with a bad marker
    task automatic send_frame();
        logic [BYTE_W-1:0] layout [HOLD_LEN];
        int                kind;
        int                len;
        for (int i = 0; i < HOLD_LEN; i++)
            layout[i] = digit_or_plain();
        layout[POS_X_TAG] = CH_X;
        layout[POS_Y_TAG] = CH_Y;
        layout[POS_Q_TAG] = CH_Q;
        layout[POS_X_VAL] = sign_or_digit();
        layout[POS_Y_VAL] = sign_or_digit();
        kind = $urandom_range(0, 99);
        len  = HOLD_LEN + $urandom_range(0, 2);
        if (kind < 10)
            len = $urandom_range(0, HOLD_LEN - 1);
        else if (kind < 18)
            len = HOLD_LEN + $urandom_range(5, 25);
        else if (kind < 25)
        begin
            case ($urandom_range(0, 2))
                0:       layout[POS_X_TAG] = plain_byte();
                1:       layout[POS_Y_TAG] = plain_byte();
                default: layout[POS_Q_TAG] = plain_byte();
            endcase
        end

        // stray words between frames
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 4))
                send_word(cmd_t'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                          next_ms());

        if ($urandom_range(0, 99) < 92)
            send_word(CMD_BYTE, CH_RESTART, next_ms());
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                send_word(CMD_QUERY, BYTE_W'($urandom_range(0, 255)), next_ms());
            send_word(CMD_BYTE, i < HOLD_LEN ? layout[i] : plain_byte(), next_ms());
        end
        if ($urandom_range(0, 99) < 95)
            send_word(CMD_BYTE, CH_END, next_ms());
        if ($urandom_range(0, 99) < 40)
            repeat ($urandom_range(1, 3))
                send_word(CMD_QUERY, BYTE_W'($urandom_range(0, 255)), next_ms());
    endtask

    // one random phase under a given limit and idling mix
    task automatic run_phase(logic [TIME_W-1:0] limit, int s_gap, int r_gap);
        int stop_at;
        drain();
        write_limit(limit);
        send_gap_pct = s_gap;
        recv_gap_pct = r_gap;
        stop_at      = words_sent + PHASE_WORDS;
        while (words_sent < stop_at)
            send_frame();
    endtask

    // main sequence
    initial
    begin
        logic [TIME_W-1:0] mid_limit;
        tracker             = new();
        rst_n              <= 1'b0;
        in_valid           <= 1'b0;
        cmd                <= CMD_BYTE;
        rx_byte            <= '0;
        now_ms             <= '0;
        cfg_valid          <= 1'b0;
        cfg_fresh_limit_ms <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no target yet, extreme frame, freshness edge, ignored bytes
        send_word(CMD_QUERY, 8'h00, 32'd0);
        send_text("$X=-999Y=+999Q=999#", 32'd1000);
        send_word(CMD_QUERY, 8'hFF, 32'd1000 + LIMIT_RESET);
        send_word(CMD_QUERY, CH_END, 32'd1001 + LIMIT_RESET);
        send_word(CMD_QUERY, CH_RESTART, 32'hFFFF_FFFF);
        // bare end marker clears the tag and leaves the target alone
        send_word(CMD_BYTE, CH_END, 32'd1050);

        // random phases over the limit extremes and idling mixes
        mid_limit = $urandom_range(1, 400);
        run_phase(32'd0, 16, 45);
        run_phase(32'hFFFF_FFFF, 45, 16);
        run_phase(mid_limit, 0, 0);

        drain();
        repeat (4) @(posedge clk);
        $display("covered %0d input words, %0d result words checked, %0d frames taken",
                 words_sent, tracker.checked, tracker.frames_taken);
        $display("limits used: reset value, zero, all ones and %0d ms", mid_limit);
        if (tracker.errors == 0 && tracker.expected_targets.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/tfp_pkg.sv
src/tfp_num_parse.sv
src/target_frame_parser.sv
verif/tb_target_frame_parser.sv
